// ===== src/h264auc_pkg.sv =====
package h264auc_pkg;

   localparam int unsigned NAL_CNT_W = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SIDE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SLICE_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_MASK = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL = 2'd3;

   localparam logic [3:0] FIRST_SLICE_MASK_RESET = 4'd7;
   localparam logic [3:0] HEADER_MASK_RESET = 4'd3;
   localparam logic [7:0] MAX_LEVEL_RESET = 8'd51;

   // NAL unit types.
   localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
   localparam logic [4:0] NAL_IDR = 5'd5;
   localparam logic [4:0] NAL_SPS = 5'd7;
   localparam logic [4:0] NAL_PPS = 5'd8;
   localparam logic [4:0] NAL_AUD = 5'd9;
   localparam logic [4:0] NAL_SLICE_FIRST = 5'd1;
   localparam logic [4:0] NAL_SLICE_LAST = 5'd4;

   // Presence bits.
   localparam logic [3:0] BIT_SPS = 4'h1;
   localparam logic [3:0] BIT_PPS = 4'h2;
   localparam logic [3:0] BIT_IDR = 4'h4;
   localparam logic [3:0] BIT_SLICE = 4'h8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic config_present;
      logic sync_point;
      logic has_slice;
      logic status;
   } rsp_payload_type;

endpackage

// ===== src/h264_access_unit_classifier_top.sv =====
// Annex B access unit classifier.
// Bytes of one buffer enter on the request channel (req_valid, req_stall,
// req_payload); the final byte of a buffer carries last_byte. For every
// buffer exactly one result leaves on the rsp_ channel, with the config,
// sync and slice flags and a status bit. Bytes without last_byte give no
// result.
// A byte is registered when accepted and processed from the input register;
// the result register is loaded when the last byte is processed, and rsp_valid
// rises with it. One byte is taken every cycle while req_stall is low; the
// start code tracking and classification of a byte is a single step of logic.
// When the receiver stalls, the result holds in its register and bytes keep
// flowing until a second last byte would need the result register; then
// req_stall rises until the pending result is taken.
// Configuration registers are written over csr_; the user must write them only
// while no buffer is in flight (not enforced here); csr_ready is always high.
// Synchronous reset clears the buffer state, drops any pending request or
// result and restores the register defaults.
module h264_access_unit_classifier_top #(
   parameter int unsigned MAX_NALS = 6
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  h264auc_pkg::req_payload_type               req_payload,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output h264auc_pkg::rsp_payload_type               rsp_payload,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [h264auc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [h264auc_pkg::CSR_DATA_W-1:0]         csr_data
);
   import h264auc_pkg::*;

   typedef enum logic [1:0] {
      PH_SEEK,
      PH_HEADER,
      PH_BODY
   } phase_type;

   localparam logic [NAL_CNT_W-1:0] NAL_LIMIT = NAL_CNT_W'(MAX_NALS);

   // Configuration registers.
   logic       output_side_ff;
   logic [3:0] first_slice_mask_ff;
   logic [3:0] header_mask_ff;
   logic [7:0] max_level_ff;

   // Input register.
   logic            in_valid_ff;
   req_payload_type in_data_ff;

   // Buffer state.
   phase_type            phase_ff, phase_in;
   logic [1:0]           zero_run_ff, zero_run_in;
   logic [NAL_CNT_W-1:0] nal_count_ff, nal_count_in;
   logic [3:0]           presence_ff, presence_in;
   logic                 header_path_ff, header_path_in;
   logic [1:0]           sps_index_ff, sps_index_in;
   logic                 level_error_ff, level_error_in;

   // Result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       fire;
   logic [4:0] kind;
   logic       first_nal;
   logic       classify;

   assign fire = in_valid_ff && !(in_data_ff.last_byte && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready = 1'b1;
   assign kind = in_data_ff.data_byte[4:0] & NAL_TYPE_MASK;

   always_comb begin
      phase_in = phase_ff;
      zero_run_in = zero_run_ff;
      nal_count_in = nal_count_ff;
      presence_in = presence_ff;
      header_path_in = header_path_ff;
      sps_index_in = sps_index_ff;
      level_error_in = level_error_ff;
      first_nal = 1'b0;
      classify = 1'b0;

      // The SPS level byte is the third byte after the SPS header.
      if (sps_index_ff != 2'd0) begin
         if (sps_index_ff == 2'd3) begin
            if (in_data_ff.data_byte > max_level_ff) begin
               level_error_in = 1'b1;
            end
            sps_index_in = 2'd0;
         end else begin
            sps_index_in = sps_index_ff + 2'd1;
         end
      end

      if (phase_ff == PH_HEADER) begin
         first_nal = !header_path_ff && (nal_count_ff == '0) && (presence_ff == '0);
         if (first_nal) begin
            if (kind == NAL_SPS || kind == NAL_PPS || kind == NAL_AUD) begin
               header_path_in = 1'b1;
               classify = 1'b1;
            end else begin
               header_path_in = 1'b0;
               if (kind == NAL_IDR) begin
                  presence_in = presence_in | BIT_IDR;
               end else if (kind >= NAL_SLICE_FIRST && kind <= NAL_SLICE_LAST) begin
                  presence_in = presence_in | BIT_SLICE;
               end
            end
         end else if (header_path_ff && !level_error_in && nal_count_ff < NAL_LIMIT) begin
            classify = 1'b1;
         end
         if (classify) begin
            if (kind == NAL_SPS) begin
               presence_in = presence_in | BIT_SPS;
               sps_index_in = 2'd1;
            end else if (kind == NAL_PPS) begin
               presence_in = presence_in | BIT_PPS;
            end else if (kind == NAL_IDR) begin
               presence_in = presence_in | BIT_IDR;
            end else begin
               presence_in = presence_in | BIT_SLICE;
            end
            nal_count_in = nal_count_ff + 1'b1;
         end
         phase_in = PH_BODY;
         zero_run_in = 2'd0;
      end else begin
         if (in_data_ff.data_byte == 8'd0) begin
            if (zero_run_ff != 2'd3) begin
               zero_run_in = zero_run_ff + 2'd1;
            end
         end else if (in_data_ff.data_byte == 8'd1 && zero_run_ff >= 2'd2) begin
            zero_run_in = 2'd0;
            // Within a NAL body a start code only matters on the header path.
            if (phase_ff == PH_SEEK || header_path_ff) begin
               phase_in = PH_HEADER;
            end
         end else begin
            zero_run_in = 2'd0;
         end
      end

      rsp_data_in = '0;
      if (level_error_in) begin
         rsp_data_in.status = 1'b1;
      end else if (output_side_ff) begin
         rsp_data_in.config_present = (presence_in & header_mask_ff) == header_mask_ff;
         rsp_data_in.sync_point = |(presence_in & BIT_IDR);
         rsp_data_in.has_slice = |(presence_in & BIT_SLICE);
      end else begin
         rsp_data_in.status = (presence_in & first_slice_mask_ff) != first_slice_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_side_ff <= 1'b0;
         first_slice_mask_ff <= FIRST_SLICE_MASK_RESET;
         header_mask_ff <= HEADER_MASK_RESET;
         max_level_ff <= MAX_LEVEL_RESET;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PH_SEEK;
         zero_run_ff <= 2'd0;
         nal_count_ff <= '0;
         presence_ff <= '0;
         header_path_ff <= 1'b0;
         sps_index_ff <= 2'd0;
         level_error_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OUTPUT_SIDE: begin
                  output_side_ff <= csr_data[0];
               end
               CSR_FIRST_SLICE_MASK: begin
                  first_slice_mask_ff <= csr_data[3:0];
               end
               CSR_HEADER_MASK: begin
                  header_mask_ff <= csr_data[3:0];
               end
               CSR_MAX_LEVEL: begin
                  max_level_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end

         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end

         if (fire && in_data_ff.last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (fire) begin
            if (in_data_ff.last_byte) begin
               phase_ff <= PH_SEEK;
               zero_run_ff <= 2'd0;
               nal_count_ff <= '0;
               presence_ff <= '0;
               header_path_ff <= 1'b0;
               sps_index_ff <= 2'd0;
               level_error_ff <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               zero_run_ff <= zero_run_in;
               nal_count_ff <= nal_count_in;
               presence_ff <= presence_in;
               header_path_ff <= header_path_in;
               sps_index_ff <= sps_index_in;
               level_error_ff <= level_error_in;
            end
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
      if (fire && in_data_ff.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== dv/h264_access_unit_classifier_top_test.sv =====
`timescale 1ns / 100ps

module h264_access_unit_classifier_top_test;
   import h264auc_pkg::*;

   localparam int NAL_LIMIT = 6;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_REPORTS = 10;

   typedef enum logic [1:0] {
      SCAN_SEEK,
      SCAN_HEADER,
      SCAN_BODY
   } scan_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the block's registers.
   logic cfg_output_side;
   logic [3:0] cfg_required_mask;
   logic [3:0] cfg_config_mask;
   logic [7:0] cfg_max_level;

   // Shadow copy of the per-buffer scan state.
   scan_state_type scan_state;
   logic [1:0] zero_run_len;
   logic [2:0] nals_classified;
   logic [3:0] seen_bits;
   logic param_set_first;
   logic [1:0] sps_payload_pos;
   logic level_too_high;

   rsp_payload_type expected_results[$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned stall_left = 0;

   h264_access_unit_classifier_top #(
      .MAX_NALS(NAL_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_cycles(input int unsigned pct);
      if ($urandom_range(99) >= pct) begin
         return 0;
      end
      if ($urandom_range(9) == 0) begin
         return $urandom_range(40, 8);
      end
      return $urandom_range(3, 1);
   endfunction

   function automatic void clear_scan_state();
      scan_state = SCAN_SEEK;
      zero_run_len = 2'd0;
      nals_classified = 3'd0;
      seen_bits = 4'd0;
      param_set_first = 1'b0;
      sps_payload_pos = 2'd0;
      level_too_high = 1'b0;
   endfunction

   function automatic void count_nal(input logic [4:0] kind);
      case (kind)
         NAL_SPS: begin
            seen_bits |= BIT_SPS;
            sps_payload_pos = 2'd1;
         end
         NAL_PPS: seen_bits |= BIT_PPS;
         NAL_IDR: seen_bits |= BIT_IDR;
         default: seen_bits |= BIT_SLICE;
      endcase
      nals_classified = nals_classified + 3'd1;
   endfunction

   function automatic void classify_byte(input req_payload_type r);
      logic [4:0] kind;
      logic first_nal;
      rsp_payload_type res;
      kind = r.data_byte[4:0] & NAL_TYPE_MASK;
      // The SPS level byte is the third byte after its header, start code or not.
      if (sps_payload_pos != 2'd0) begin
         if (sps_payload_pos == 2'd3) begin
            if (r.data_byte > cfg_max_level) begin
               level_too_high = 1'b1;
            end
            sps_payload_pos = 2'd0;
         end else begin
            sps_payload_pos = sps_payload_pos + 2'd1;
         end
      end
      if (scan_state == SCAN_HEADER) begin
         first_nal = !param_set_first && nals_classified == 3'd0 && seen_bits == 4'd0;
         if (first_nal) begin
            if (kind == NAL_SPS || kind == NAL_PPS || kind == NAL_AUD) begin
               param_set_first = 1'b1;
               count_nal(kind);
            end else begin
               param_set_first = 1'b0;
               if (kind == NAL_IDR) begin
                  seen_bits |= BIT_IDR;
               end else if (kind >= NAL_SLICE_FIRST && kind <= NAL_SLICE_LAST) begin
                  seen_bits |= BIT_SLICE;
               end
            end
         end else if (param_set_first && !level_too_high && nals_classified < NAL_LIMIT) begin
            count_nal(kind);
         end
         scan_state = SCAN_BODY;
         zero_run_len = 2'd0;
      end else if (r.data_byte == 8'h00) begin
         if (zero_run_len != 2'd3) begin
            zero_run_len = zero_run_len + 2'd1;
         end
      end else if (r.data_byte == 8'h01 && zero_run_len >= 2'd2) begin
         zero_run_len = 2'd0;
         if (scan_state == SCAN_SEEK || param_set_first) begin
            scan_state = SCAN_HEADER;
         end
      end else begin
         zero_run_len = 2'd0;
      end
      if (r.last_byte) begin
         res = '0;
         if (level_too_high) begin
            res.status = 1'b1;
         end else if (cfg_output_side) begin
            res.config_present = (seen_bits & cfg_config_mask) == cfg_config_mask;
            res.sync_point = (seen_bits & BIT_IDR) != 4'd0;
            res.has_slice = (seen_bits & BIT_SLICE) != 4'd0;
         end else begin
            res.status = (seen_bits & cfg_required_mask) != cfg_required_mask;
         end
         expected_results.push_back(res);
         clear_scan_state();
      end
   endfunction

   // All driving tasks start and end just after a falling edge.
   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      gap = idle_cycles(gap_pct);
      repeat (gap) @(negedge clock);
      req_payload.data_byte = data;
      req_payload.last_byte = last;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_byte(req_payload);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_bytes(input logic [7:0] au[$]);
      foreach (au[i]) begin
         send_byte(au[i], i == au.size() - 1);
      end
   endtask

   task automatic wait_results_drained();
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_index = idx;
      csr_data = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_OUTPUT_SIDE: cfg_output_side = value[0];
         CSR_FIRST_SLICE_MASK: cfg_required_mask = value[3:0];
         CSR_HEADER_MASK: cfg_config_mask = value[3:0];
         CSR_MAX_LEVEL: cfg_max_level = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Registers change only with no buffer in flight.
   task automatic apply_settings(input logic side, input logic [3:0] required,
                                 input logic [3:0] config_mask, input logic [7:0] level);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_csr(CSR_OUTPUT_SIDE, {7'd0, side});
      write_csr(CSR_FIRST_SLICE_MASK, {4'd0, required});
      write_csr(CSR_HEADER_MASK, {4'd0, config_mask});
      write_csr(CSR_MAX_LEVEL, level);
   endtask

   function automatic logic [7:0] body_byte();
      return ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
   endfunction

   // Mostly well-formed access units with random content, some noise and
   // some broken start codes.
   function automatic void build_access_unit(ref logic [7:0] au[$]);
      int unsigned nal_total;
      int unsigned zeros;
      int unsigned body_len;
      logic [4:0] kind;
      au.delete();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(12, 1)) begin
            case ($urandom_range(3))
               0: au.push_back(8'h00);
               1: au.push_back(8'h01);
               default: au.push_back(8'($urandom_range(255)));
            endcase
         end
         return;
      end
      repeat ($urandom_range(2)) au.push_back(8'($urandom_range(255)));
      nal_total = $urandom_range(8, 1);
      for (int i = 0; i < nal_total; i++) begin
         case ($urandom_range(19))
            0: zeros = 1;
            1, 2: zeros = 3;
            default: zeros = 2;
         endcase
         repeat (zeros) au.push_back(8'h00);
         au.push_back(8'h01);
         if (i == 0 && $urandom_range(9) < 7) begin
            case ($urandom_range(2))
               0: kind = NAL_SPS;
               1: kind = NAL_PPS;
               default: kind = NAL_AUD;
            endcase
         end else begin
            case ($urandom_range(5))
               0: kind = NAL_SLICE_FIRST;
               1: kind = NAL_IDR;
               2: kind = NAL_SPS;
               3: kind = NAL_PPS;
               default: kind = 5'($urandom_range(31));
            endcase
         end
         au.push_back({3'($urandom_range(7)), kind});
         if (kind == NAL_SPS && $urandom_range(4) != 0) begin
            body_len = $urandom_range(5, 3);
         end else begin
            body_len = $urandom_range(4);
         end
         for (int j = 0; j < body_len; j++) begin
            if (kind == NAL_SPS && j == 2) begin
               case ($urandom_range(3))
                  0: au.push_back(cfg_max_level);
                  1: au.push_back(cfg_max_level + 8'd1);
                  default: au.push_back(8'($urandom_range(255)));
               endcase
            end else begin
               au.push_back(body_byte());
            end
         end
      end
   endfunction

   task automatic run_random_bytes(input int unsigned budget, input bit pause_for_results);
      logic [7:0] au[$];
      int unsigned sent;
      sent = 0;
      case ($urandom_range(2))
         0: gap_pct = 0;
         1: gap_pct = 20;
         default: gap_pct = 60;
      endcase
      case ($urandom_range(2))
         0: stall_pct = 0;
         1: stall_pct = 20;
         default: stall_pct = 60;
      endcase
      while (sent < budget) begin
         build_access_unit(au);
         send_bytes(au);
         sent += au.size();
         if (pause_for_results && $urandom_range(2) == 0) begin
            wait_results_drained();
         end
      end
   endtask

   task automatic test_directed_buffers();
      logic [7:0] au[$];
      gap_pct = 0;
      stall_pct = 0;
      // No start code at all: nothing is present, so the reset mask fails.
      au = '{8'h00, 8'hFF};
      send_bytes(au);
      // Junk before a long start code, SPS with level equal to the limit,
      // then PPS and IDR.
      au = '{8'hAB, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h33,
             8'h00, 8'h00, 8'h01, 8'h68, 8'h00, 8'h00, 8'h01, 8'h65};
      send_bytes(au);
      // Level one above the limit.
      au = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h34};
      send_bytes(au);
      // The buffer ends before the SPS level byte.
      au = '{8'h00, 8'h00, 8'h01, 8'hE7, 8'h42};
      send_bytes(au);
   endtask

   task automatic test_input_side_masks();
      apply_settings(1'b0, 4'd0, 4'($urandom_range(15)), MAX_LEVEL_RESET);
      run_random_bytes(130, 1'b0);
      apply_settings(1'b0, 4'hF, 4'($urandom_range(15)), MAX_LEVEL_RESET);
      run_random_bytes(130, 1'b0);
      repeat (2) begin
         apply_settings(1'b0, 4'($urandom_range(15)), 4'($urandom_range(15)),
                        8'($urandom_range(255)));
         run_random_bytes(130, 1'b0);
      end
   endtask

   task automatic test_output_side_flags();
      apply_settings(1'b1, 4'($urandom_range(15)), 4'd0, 8'($urandom_range(255)));
      run_random_bytes(130, 1'b0);
      apply_settings(1'b1, 4'($urandom_range(15)), 4'hF, 8'($urandom_range(255)));
      run_random_bytes(130, 1'b0);
      apply_settings(1'b1, 4'($urandom_range(15)), HEADER_MASK_RESET, MAX_LEVEL_RESET);
      run_random_bytes(130, 1'b0);
      apply_settings(1'b1, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     8'($urandom_range(255)));
      run_random_bytes(130, 1'b0);
   endtask

   task automatic test_level_extremes();
      apply_settings(1'b1, FIRST_SLICE_MASK_RESET, HEADER_MASK_RESET, 8'd0);
      run_random_bytes(80, 1'b0);
      apply_settings(1'b0, FIRST_SLICE_MASK_RESET, HEADER_MASK_RESET, 8'hFF);
      run_random_bytes(80, 1'b0);
   endtask

   task automatic test_sender_pause();
      apply_settings(1'($urandom_range(1)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                     8'($urandom_range(255)));
      run_random_bytes(180, 1'b1);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         apply_settings(1'($urandom_range(1)), 4'($urandom_range(15)),
                        4'($urandom_range(15)), 8'($urandom_range(255)));
         run_random_bytes(60, 1'b0);
      end
   endtask

   // Receiver stall pattern.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         stall_left = idle_cycles(stall_pct);
      end
   end

   // Result bits print in the order config, sync, slice, status.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result %4b", rsp_payload));
         end else begin
            rsp_payload_type want;
            want = expected_results.pop_front();
            if (rsp_payload !== want) begin
               note_failure($sformatf("result mismatch: expected %4b, got %4b",
                                      want, rsp_payload));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      cfg_output_side = 1'b0;
      cfg_required_mask = FIRST_SLICE_MASK_RESET;
      cfg_config_mask = HEADER_MASK_RESET;
      cfg_max_level = MAX_LEVEL_RESET;
      clear_scan_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_buffers();
      test_input_side_masks();
      test_output_side_flags();
      test_level_extremes();
      test_sender_pause();
      test_random_settings();

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", expected_results.size()));
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
